[design/dhcpp_pkg.sv]
// ----------------------------------------------------------------------------
// dhcpp_pkg
// Types, option codes and constants shared by the DHCP option parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dhcpp_pkg;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_BYTE   = 2'd1,
		KIND_PRESET = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_CODE  = 2'd0,
		PH_LEN   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_MALFORMED  = 2'd1,
		STATUS_ZERO_LEASE = 2'd2,
		STATUS_NO_TYPE    = 2'd3
	} status_t;

	localparam logic [7:0] OPT_PAD     = 8'd0;
	localparam logic [7:0] OPT_SUBNET  = 8'd1;
	localparam logic [7:0] OPT_ROUTER  = 8'd3;
	localparam logic [7:0] OPT_DNS     = 8'd6;
	localparam logic [7:0] OPT_TTL     = 8'd23;
	localparam logic [7:0] OPT_LEASE   = 8'd51;
	localparam logic [7:0] OPT_MSGTYPE = 8'd53;
	localparam logic [7:0] OPT_SERVER  = 8'd54;
	localparam logic [7:0] OPT_RENEW   = 8'd58;
	localparam logic [7:0] OPT_REBIND  = 8'd59;
	localparam logic [7:0] OPT_END     = 8'd255;

	localparam logic [7:0]  TYPE_ACK       = 8'd5;
	localparam logic [31:0] INFINITE_LEASE = 32'hFFFF_FFFF;
	localparam logic [7:0]  TTL_RESET      = 8'd64;

	// value byte positions that complete the first and second 32-bit word
	localparam logic [7:0] IDX_WORD0 = 8'd3;
	localparam logic [7:0] IDX_WORD1 = 8'd7;

	localparam int N_ADDR   = 6;
	localparam int A_SUBNET = 0;
	localparam int A_GW     = 1;
	localparam int A_ALTGW  = 2;
	localparam int A_DNS    = 3;
	localparam int A_ALTDNS = 4;
	localparam int A_SERVER = 5;

	localparam int N_TIME   = 3;
	localparam int T_LEASE  = 0;
	localparam int T_RENEW  = 1;
	localparam int T_REBIND = 2;

	typedef struct packed {
		logic [31:0] renew;
		logic [31:0] rebind;
		status_t     status;
	} fin_t;

endpackage

`default_nettype wire

[design/dhcpp_if.sv]
// ----------------------------------------------------------------------------
// dhcpp_if
// Valid/ready channels of the DHCP option parser: option requests in,
// packet summaries out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhcpp_opt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  option_byte;
	logic [31:0] preset_address;

	modport source (output valid, kind, option_byte, preset_address, input ready);
	modport sink   (input valid, kind, option_byte, preset_address, output ready);
endinterface

interface dhcpp_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  dhcp_type;
	logic [31:0] net_mask;
	logic [31:0] gateway;
	logic [31:0] alt_gateway;
	logic [31:0] dns_server;
	logic [31:0] alt_dns_server;
	logic [31:0] server_id;
	logic [7:0]  ip_ttl;
	logic [31:0] lease_seconds;
	logic [31:0] renew_seconds;
	logic [31:0] rebind_seconds;
	logic [1:0]  status;

	modport source (output valid, dhcp_type, net_mask, gateway, alt_gateway,
		dns_server, alt_dns_server, server_id, ip_ttl, lease_seconds,
		renew_seconds, rebind_seconds, status, input ready);
	modport sink (input valid, dhcp_type, net_mask, gateway, alt_gateway,
		dns_server, alt_dns_server, server_id, ip_ttl, lease_seconds,
		renew_seconds, rebind_seconds, status, output ready);
endinterface

`default_nettype wire

[design/dhcpp_finish.sv]
// ----------------------------------------------------------------------------
// dhcpp_finish
// End-of-options summary: status code and T1/T2 defaults for an ACK.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcpp_finish
	import dhcpp_pkg::*;
(
	input  wire logic [7:0]  msg_type,
	input  wire logic        malformed,
	input  wire logic [31:0] lease,
	input  wire logic [31:0] renew,
	input  wire logic [31:0] rebind,
	output fin_t             fin
);

	logic        is_ack;
	logic        dflt;
	logic [31:0] half;
	logic [31:0] seven_eighths;

	assign is_ack = (msg_type == TYPE_ACK);
	assign dflt   = !malformed && is_ack && (lease != '0) && (lease != INFINITE_LEASE);
	assign half   = {1'b0, lease[31:1]};
	// floor(7L/8) = L - ceil(L/8)
	assign seven_eighths = lease - {3'b000, lease[31:3]} - {31'd0, |lease[2:0]};

	always_comb begin
		fin.renew  = (dflt && renew == '0) ? half : renew;
		fin.rebind = (dflt && rebind == '0) ? seven_eighths : rebind;
		if (malformed) begin
			fin.status = STATUS_MALFORMED;
		end else if (msg_type == '0) begin
			fin.status = STATUS_NO_TYPE;
		end else if (is_ack && lease == '0) begin
			fin.status = STATUS_ZERO_LEASE;
		end else begin
			fin.status = STATUS_OK;
		end
	end

endmodule

`default_nettype wire

[design/dhcp_option_parser.sv]
// ----------------------------------------------------------------------------
// dhcp_option_parser
// Walks DHCP option records byte by byte and reports learned values at END.
// ----------------------------------------------------------------------------
// Usage:
//   opt    - request channel: kind selects clear, option byte or preset server
//            address. Every accepted request but the unused kind updates state.
//   result - one summary per END code (255 seen where a code is expected).
//   cfg_we/cfg_wdata - bound_mode; write only while the block is idle.
// Timing:
//   Requests are registered on acceptance and processed from the input register;
//   an END byte there loads the summary into the output register, where result
//   can accept it.
//   One request per cycle is sustained while no END waits on an unread summary;
//   the single state update per byte sets that figure.
// Stall:
//   The summary sits in an output register. Requests keep flowing while it
//   waits; only an END request behind an unread summary holds the input
//   register, which then drops opt.ready.
// Reset:
//   arst_n clears the parse state, all learned values, the TTL to 64,
//   bound_mode and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_option_parser
	import dhcpp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	dhcpp_opt_if.sink       opt,
	dhcpp_res_if.source     result
);

	// input register
	logic        s1_valid;
	kind_t       s1_kind;
	logic [7:0]  s1_byte;
	logic [31:0] s1_addr;

	// parse and learned state
	logic        bound_q;
	phase_t      phase_q,  phase_d;
	logic [7:0]  code_q,   code_d;
	logic [7:0]  left_q,   left_d;
	logic [7:0]  idx_q,    idx_d;
	logic [31:0] shift_q,  shift_d;
	logic [31:0] addr_q  [N_ADDR];
	logic [31:0] addr_d  [N_ADDR];
	logic [31:0] times_q [N_TIME];
	logic [31:0] times_d [N_TIME];
	logic [7:0]  ttl_q,    ttl_d;
	logic [7:0]  type_q,   type_d;
	logic        malf_q,   malf_d;

	logic        s1_end;
	logic        s1_adv;
	logic        out_free;
	logic        fin_load;
	logic [31:0] acc;
	logic        word0;
	logic        word1;
	fin_t        fin;

	logic        out_valid_q;

	assign s1_end   = s1_valid && s1_kind == KIND_BYTE && phase_q == PH_CODE
		&& s1_byte == OPT_END;
	assign out_free = !out_valid_q || result.ready;
	assign s1_adv   = s1_valid && (!s1_end || out_free);
	assign opt.ready = !s1_valid || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (opt.ready) begin
			s1_valid <= opt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (opt.ready && opt.valid) begin
			s1_kind <= kind_t'(opt.kind);
			s1_byte <= opt.option_byte;
			s1_addr <= opt.preset_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= 1'b0;
		end else if (cfg_we) begin
			bound_q <= cfg_wdata;
		end
	end

	dhcpp_finish u_finish (
		.msg_type  (type_q),
		.malformed (malf_q),
		.lease     (times_q[T_LEASE]),
		.renew     (times_q[T_RENEW]),
		.rebind    (times_q[T_REBIND]),
		.fin       (fin)
	);

	assign acc   = {shift_q[23:0], s1_byte};
	assign word0 = (idx_q == IDX_WORD0);
	assign word1 = (idx_q == IDX_WORD1);

	always_comb begin
		phase_d  = phase_q;
		code_d   = code_q;
		left_d   = left_q;
		idx_d    = idx_q;
		shift_d  = shift_q;
		addr_d   = addr_q;
		times_d  = times_q;
		ttl_d    = ttl_q;
		type_d   = type_q;
		malf_d   = malf_q;
		fin_load = 1'b0;
		if (s1_adv) begin
			case (s1_kind)
				KIND_CLEAR: begin
					phase_d = PH_CODE;
					code_d  = '0;
					left_d  = '0;
					idx_d   = '0;
					shift_d = '0;
					for (int i = 0; i < N_ADDR; i++) addr_d[i] = '0;
					for (int i = 0; i < N_TIME; i++) times_d[i] = '0;
					ttl_d  = TTL_RESET;
					type_d = '0;
					malf_d = 1'b0;
				end
				KIND_PRESET: begin
					addr_d[A_SERVER] = s1_addr;
				end
				KIND_BYTE: begin
					case (phase_q)
						PH_CODE: begin
							if (s1_byte == OPT_END) begin
								fin_load          = 1'b1;
								times_d[T_RENEW]  = fin.renew;
								times_d[T_REBIND] = fin.rebind;
								type_d  = '0;
								malf_d  = 1'b0;
								code_d  = '0;
								left_d  = '0;
								idx_d   = '0;
								shift_d = '0;
							end else if (s1_byte != OPT_PAD) begin
								code_d  = s1_byte;
								phase_d = PH_LEN;
							end
						end
						PH_LEN: begin
							left_d  = s1_byte;
							idx_d   = '0;
							shift_d = '0;
							if ((code_q == OPT_ROUTER || code_q == OPT_DNS)
									&& s1_byte[1:0] != 2'b00) begin
								malf_d = 1'b1;
							end
							phase_d = (s1_byte == '0) ? PH_CODE : PH_VALUE;
						end
						PH_VALUE: begin
							if (left_q != '0) begin
								shift_d = acc;
								if (!malf_q) begin
									case (code_q)
										OPT_SUBNET: if (word0) addr_d[A_SUBNET] = acc;
										OPT_SERVER: begin
											if (word0 && addr_q[A_SERVER] == '0) begin
												addr_d[A_SERVER] = acc;
											end
										end
										OPT_ROUTER: begin
											if (word0) addr_d[A_GW] = acc;
											if (word1) addr_d[A_ALTGW] = acc;
										end
										OPT_DNS: begin
											if (word0) addr_d[A_DNS] = acc;
											if (word1) addr_d[A_ALTDNS] = acc;
										end
										OPT_TTL: if (idx_q == '0) ttl_d = s1_byte;
										OPT_MSGTYPE: begin
											if (idx_q == '0 && type_q == '0) type_d = s1_byte;
										end
										OPT_LEASE: if (word0 && !bound_q) times_d[T_LEASE] = acc;
										OPT_RENEW: if (word0 && !bound_q) times_d[T_RENEW] = acc;
										OPT_REBIND: begin
											if (word0 && !bound_q) times_d[T_REBIND] = acc;
										end
										default: ;
									endcase
								end
								idx_d  = idx_q + 8'd1;
								left_d = left_q - 8'd1;
								if (left_q == 8'd1) phase_d = PH_CODE;
							end else begin
								phase_d = PH_CODE;
								code_d  = '0;
								left_d  = '0;
								idx_d   = '0;
								shift_d = '0;
							end
						end
						default: begin
							phase_d = PH_CODE;
							code_d  = '0;
							left_d  = '0;
							idx_d   = '0;
							shift_d = '0;
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			code_q  <= '0;
			left_q  <= '0;
			idx_q   <= '0;
			shift_q <= '0;
			for (int i = 0; i < N_ADDR; i++) addr_q[i] <= '0;
			for (int i = 0; i < N_TIME; i++) times_q[i] <= '0;
			ttl_q   <= TTL_RESET;
			type_q  <= '0;
			malf_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			code_q  <= code_d;
			left_q  <= left_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
			addr_q  <= addr_d;
			times_q <= times_d;
			ttl_q   <= ttl_d;
			type_q  <= type_d;
			malf_q  <= malf_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			result.dhcp_type      <= type_q;
			result.net_mask       <= addr_q[A_SUBNET];
			result.gateway        <= addr_q[A_GW];
			result.alt_gateway    <= addr_q[A_ALTGW];
			result.dns_server     <= addr_q[A_DNS];
			result.alt_dns_server <= addr_q[A_ALTDNS];
			result.server_id      <= addr_q[A_SERVER];
			result.ip_ttl         <= ttl_q;
			result.lease_seconds  <= times_q[T_LEASE];
			result.renew_seconds  <= fin.renew;
			result.rebind_seconds <= fin.rebind;
			result.status         <= fin.status;
		end
	end

	assign result.valid = out_valid_q;

	a_load_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |-> s1_end && out_free)
		else $error("summary loaded without an END request");

	a_value_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VALUE |-> left_q != '0)
		else $error("value phase with no bytes left");

	a_malformed_from_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(malf_q) |-> $past(phase_q == PH_LEN))
		else $error("malformed flag set outside a length byte");

	a_clear_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && s1_kind == KIND_CLEAR) |=> ttl_q == TTL_RESET && times_q[T_LEASE] == '0)
		else $error("clear request did not restore defaults");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!opt.ready |-> s1_valid && s1_end && out_valid_q)
		else $error("input stalled without a blocked END request");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DHCP option parser. Option requests are queued
// as directed and random packets, driven through the valid/ready channel and
// fed to an in-bench model of the learned-value store as they are accepted.
// Every summary leaving the block is checked against the model's prediction.
// ----------------------------------------------------------------------------

module tb_top;
	import dhcpp_pkg::*;

	localparam int PHASE_ITEMS  = 635;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 300;

	typedef struct {
		kind_t       kind;
		logic [7:0]  b;
		logic [31:0] addr;
		logic        after_drain;
	} request_t;

	typedef struct {
		logic [7:0]  mtype;
		logic [31:0] subnet;
		logic [31:0] gw;
		logic [31:0] alt_gw;
		logic [31:0] dns;
		logic [31:0] alt_dns;
		logic [31:0] server;
		logic [7:0]  ttl;
		logic [31:0] lease;
		logic [31:0] renew;
		logic [31:0] rebind;
		status_t     status;
	} summary_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic cfg_we    = 1'b0;
	logic cfg_wdata = 1'b0;
	logic req_valid = 1'b0;
	logic sum_ready = 1'b0;
	request_t cur_req = '{KIND_CLEAR, 8'h00, 32'h0, 1'b0};

	request_t pending_requests[$];
	summary_t summaries_due[$];
	int errors     = 0;
	int n_queued   = 0;
	int n_accepted = 0;
	int n_results  = 0;
	int hold_left  = 0;
	logic hold_done  = 1'b0;
	logic drain_next = 1'b0;

	// model state
	logic        m_bound;
	phase_t      m_phase;
	logic [7:0]  m_code, m_left, m_idx, m_ttl, m_type;
	logic [31:0] m_acc;
	logic [31:0] m_addr[N_ADDR];
	logic [31:0] m_times[N_TIME];
	logic        m_bad;

	dhcpp_opt_if opt_ch();
	dhcpp_res_if res_ch();

	assign opt_ch.valid          = req_valid;
	assign opt_ch.kind           = cur_req.kind;
	assign opt_ch.option_byte    = cur_req.b;
	assign opt_ch.preset_address = cur_req.addr;
	assign res_ch.ready          = sum_ready;

	dhcp_option_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.opt      (opt_ch),
		.result   (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// model of the parser
	// ------------------------------------------------------------------
	task automatic clear_parse();
		m_phase = PH_CODE;
		m_code  = 8'd0;
		m_left  = 8'd0;
		m_idx   = 8'd0;
		m_acc   = 32'd0;
	endtask

	task automatic clear_learned();
		for (int i = 0; i < N_ADDR; i++) m_addr[i] = 32'd0;
		for (int i = 0; i < N_TIME; i++) m_times[i] = 32'd0;
		m_ttl  = TTL_RESET;
		m_type = 8'd0;
		m_bad  = 1'b0;
		clear_parse();
	endtask

	task automatic close_packet();
		summary_t s;
		status_t st;
		logic [31:0] lease;
		logic [34:0] prod;
		st = STATUS_OK;
		lease = m_times[T_LEASE];
		if (m_bad)
			st = STATUS_MALFORMED;
		else if (m_type == 8'd0)
			st = STATUS_NO_TYPE;
		else if (m_type == TYPE_ACK) begin
			if (lease == 32'd0)
				st = STATUS_ZERO_LEASE;
			else if (lease != INFINITE_LEASE) begin
				if (m_times[T_RENEW] == 32'd0) m_times[T_RENEW] = lease >> 1;
				if (m_times[T_REBIND] == 32'd0) begin
					// 7/8 of the lease, widened so the product cannot wrap
					prod = {3'b000, lease} * 35'd7;
					m_times[T_REBIND] = prod[34:3];
				end
			end
		end
		s.mtype   = m_type;
		s.subnet  = m_addr[A_SUBNET];
		s.gw      = m_addr[A_GW];
		s.alt_gw  = m_addr[A_ALTGW];
		s.dns     = m_addr[A_DNS];
		s.alt_dns = m_addr[A_ALTDNS];
		s.server  = m_addr[A_SERVER];
		s.ttl     = m_ttl;
		s.lease   = m_times[T_LEASE];
		s.renew   = m_times[T_RENEW];
		s.rebind  = m_times[T_REBIND];
		s.status  = st;
		summaries_due.push_back(s);
		m_type = 8'd0;
		m_bad  = 1'b0;
		clear_parse();
	endtask

	task automatic take_value(logic [7:0] b);
		logic [31:0] acc;
		logic word_done, times_ok;
		acc = {m_acc[23:0], b};
		m_acc = acc;
		word_done = (m_idx == IDX_WORD0);
		times_ok = !m_bound;
		if (!m_bad) begin
			case (m_code)
				OPT_SUBNET: if (word_done) m_addr[A_SUBNET] = acc;
				OPT_SERVER: if (word_done && m_addr[A_SERVER] == 32'd0) m_addr[A_SERVER] = acc;
				OPT_ROUTER: begin
					if (word_done) m_addr[A_GW] = acc;
					if (m_idx == IDX_WORD1) m_addr[A_ALTGW] = acc;
				end
				OPT_DNS: begin
					if (word_done) m_addr[A_DNS] = acc;
					if (m_idx == IDX_WORD1) m_addr[A_ALTDNS] = acc;
				end
				OPT_TTL: if (m_idx == 8'd0) m_ttl = b;
				OPT_MSGTYPE: if (m_idx == 8'd0 && m_type == 8'd0) m_type = b;
				OPT_LEASE: if (word_done && times_ok) m_times[T_LEASE] = acc;
				OPT_RENEW: if (word_done && times_ok) m_times[T_RENEW] = acc;
				OPT_REBIND: if (word_done && times_ok) m_times[T_REBIND] = acc;
				default: ;
			endcase
		end
		m_idx  = m_idx + 8'd1;
		m_left = m_left - 8'd1;
		if (m_left == 8'd0) m_phase = PH_CODE;
	endtask

	task automatic parse_request(request_t q);
		case (q.kind)
			KIND_CLEAR: clear_learned();
			KIND_PRESET: m_addr[A_SERVER] = q.addr;
			KIND_BYTE: begin
				if (m_phase == PH_CODE) begin
					if (q.b == OPT_END)
						close_packet();
					else if (q.b != OPT_PAD) begin
						m_code  = q.b;
						m_phase = PH_LEN;
					end
				end else if (m_phase == PH_LEN) begin
					m_left = q.b;
					m_idx  = 8'd0;
					m_acc  = 32'd0;
					if ((m_code == OPT_ROUTER || m_code == OPT_DNS) && q.b[1:0] != 2'd0)
						m_bad = 1'b1;
					m_phase = (q.b == 8'd0) ? PH_CODE : PH_VALUE;
				end else if (m_phase == PH_VALUE && m_left != 8'd0)
					take_value(q.b);
				else
					clear_parse();
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// request driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin : request_driver
		logic take;
		logic idle_on;
		if (req_valid && opt_ch.ready) begin
			parse_request(cur_req);
			n_accepted++;
		end
		if (!req_valid || opt_ch.ready) begin
			idle_on = !(n_accepted >= 900 && n_accepted < 1300);
			take = (pending_requests.size() != 0);
			if (take && pending_requests[0].after_drain && summaries_due.size() != 0)
				take = 1'b0;
			if (take && idle_on && $urandom_range(0, 99) < 25)
				take = 1'b0;
			if (take) begin
				cur_req <= pending_requests.pop_front();
				req_valid <= 1'b1;
			end else
				req_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// summary monitor
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endfunction

	// one long hold-off to back the parser up into its input
	always @(posedge clk) begin : hold_counter
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && n_results >= 15) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin : summary_monitor
		summary_t want;
		logic go;
		if (arst_n && sum_ready && res_ch.valid) begin
			n_results++;
			if (summaries_due.size() == 0) begin
				$error("summary with none outstanding");
				errors++;
			end else begin
				want = summaries_due.pop_front();
				check_field("dhcp_type", 32'(want.mtype), 32'(res_ch.dhcp_type));
				check_field("net_mask", want.subnet, res_ch.net_mask);
				check_field("gateway", want.gw, res_ch.gateway);
				check_field("alt_gateway", want.alt_gw, res_ch.alt_gateway);
				check_field("dns_server", want.dns, res_ch.dns_server);
				check_field("alt_dns_server", want.alt_dns, res_ch.alt_dns_server);
				check_field("server_id", want.server, res_ch.server_id);
				check_field("ip_ttl", 32'(want.ttl), 32'(res_ch.ip_ttl));
				check_field("lease_seconds", want.lease, res_ch.lease_seconds);
				check_field("renew_seconds", want.renew, res_ch.renew_seconds);
				check_field("rebind_seconds", want.rebind, res_ch.rebind_seconds);
				check_field("status", 32'(want.status), 32'(res_ch.status));
			end
		end
		if (hold_left != 0)
			go = 1'b0;
		else if (!(n_results >= 35 && n_results < 55) && $urandom_range(0, 99) < 25)
			go = 1'b0;
		else
			go = 1'b1;
		sum_ready <= go;
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic send(kind_t k, logic [7:0] b, logic [31:0] a);
		request_t q;
		q.kind = k;
		q.b = b;
		q.addr = a;
		q.after_drain = drain_next;
		drain_next = 1'b0;
		pending_requests.push_back(q);
		if (k != KIND_UNUSED) n_queued++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send(KIND_BYTE, b, $urandom);
	endtask

	task automatic send_option(logic [7:0] code, int len, logic [31:0] word);
		logic [63:0] val;
		val = {word, $urandom};
		send_byte(code);
		send_byte(len[7:0]);
		for (int i = 0; i < len; i++)
			send_byte(i < 8 ? val[63 - 8 * i -: 8] : 8'($urandom));
	endtask

	function automatic logic [31:0] pick_seconds();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return INFINITE_LEASE;
			2: return 32'($urandom_range(1, 5000));
			3: return 32'hFFFF_FFFE;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_address();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic is_known(logic [7:0] c);
		return c == OPT_SUBNET || c == OPT_ROUTER || c == OPT_DNS || c == OPT_TTL ||
			c == OPT_LEASE || c == OPT_MSGTYPE || c == OPT_SERVER ||
			c == OPT_RENEW || c == OPT_REBIND;
	endfunction

	function automatic int word_len();
		return ($urandom_range(0, 9) != 0) ? 4 : $urandom_range(0, 6);
	endfunction

	function automatic int list_len();
		return ($urandom_range(0, 9) != 0) ? 4 * $urandom_range(0, 3) : $urandom_range(1, 13);
	endfunction

	function automatic logic [31:0] pick_type();
		logic [7:0] t;
		t = ($urandom_range(0, 9) < 6) ? TYPE_ACK : 8'($urandom_range(0, 8));
		return {t, 24'($urandom)};
	endfunction

	task automatic build_packet();
		int r;
		logic [7:0] code;
		r = $urandom_range(0, 99);
		if (r < 8)
			send(KIND_CLEAR, 8'($urandom), $urandom);
		else if (r < 14)
			send(KIND_PRESET, 8'($urandom), pick_address());
		else if (r < 17)
			send(KIND_UNUSED, 8'($urandom), $urandom);
		else if (r < 20)
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
		drain_next = ($urandom_range(0, 29) == 0);
		if ($urandom_range(0, 4) != 0)
			send_option(OPT_MSGTYPE, ($urandom_range(0, 9) != 0) ? 1 : $urandom_range(0, 3),
				pick_type());
		repeat ($urandom_range(0, 7)) begin
			if ($urandom_range(0, 5) == 0) send_byte(OPT_PAD);
			case ($urandom_range(0, 10))
				0: send_option(OPT_SUBNET, word_len(), pick_address());
				1: send_option(OPT_ROUTER, list_len(), pick_address());
				2: send_option(OPT_DNS, list_len(), pick_address());
				3: send_option(OPT_TTL, ($urandom_range(0, 6) != 0) ? 1 : $urandom_range(0, 3),
					$urandom);
				4: send_option(OPT_LEASE, word_len(), pick_seconds());
				5: send_option(OPT_RENEW, word_len(), pick_seconds());
				6: send_option(OPT_REBIND, word_len(), pick_seconds());
				7: send_option(OPT_SERVER, word_len(), pick_address());
				8: send_option(OPT_MSGTYPE, 1, pick_type());
				default: begin
					do code = 8'($urandom_range(2, 254)); while (is_known(code));
					send_option(code, ($urandom_range(0, 49) != 0) ? $urandom_range(0, 8)
						: $urandom_range(9, 255), $urandom);
				end
			endcase
		end
		// now and then a packet is cut short and runs into the next one
		if ($urandom_range(0, 19) != 0) send_byte(OPT_END);
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || req_valid || summaries_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_bound(logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_bound = v;
	endtask

	initial begin : sequencer
		m_bound = 1'b0;
		clear_learned();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 3; p++) begin
			write_bound(p == 1);
			if (p == 0) begin
				// ACK with a zero lease, with a pad in front
				send_byte(OPT_PAD);
				send_option(OPT_MSGTYPE, 1, {TYPE_ACK, 24'h0});
				send_option(OPT_LEASE, 4, 32'h0);
				send_byte(OPT_END);
				// short router list, sent once everything before has drained
				drain_next = 1'b1;
				send_option(OPT_ROUTER, 2, 32'hFFFF_0000);
				send_option(OPT_MSGTYPE, 1, {TYPE_ACK, 24'h0});
				send_byte(OPT_END);
				send(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF);
				send(KIND_PRESET, 8'h00, 32'h0000_0000);
				send(KIND_PRESET, 8'hFF, 32'hFFFF_FFFF);
				send(KIND_CLEAR, 8'hFF, 32'hFFFF_FFFF);
				send_byte(OPT_END);
			end
			while (n_queued < (p + 1) * PHASE_ITEMS) build_packet();
			wait_idle();
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
